>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock with an active-low reset.
`define AHM_ASSERT_CLK(label, clock, rstn, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) prop) \
		else $error(msg);

// Concurrent assertion on the block clock and reset.
`define AHM_ASSERT(label, prop, msg) `AHM_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

>>> src/ahm_pkg.sv
package ahm_pkg;

	localparam int ANGLE_FRAC_BITS = 8;
	localparam int GAIN_FRAC_BITS  = 16;
	localparam int SHIFT           = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;

	localparam int NUM_AXES   = 3;
	localparam int NUM_MOTORS = 6;
	localparam int AX_ROLL    = 0;
	localparam int AX_PITCH   = 1;
	localparam int AX_YAW     = 2;

	localparam int IN_W    = 17;
	localparam int ERR_W   = 18;
	localparam int DIFF_W  = 19;
	localparam int SUM_W   = 29;
	localparam int SUM_X_W = SUM_W + 1;
	localparam int GAIN_W  = 24;
	localparam int ILIM_W  = 28;
	localparam int OLIM_W  = 15;
	localparam int PWM_W   = 16;
	localparam int CORR_W  = 16;
	localparam int MIX_W   = 19;

	localparam int PKP_W = GAIN_W + ERR_W + 1;
	localparam int PKI_W = GAIN_W + SUM_W + 1;
	localparam int PKD_W = GAIN_W + DIFF_W + 1;
	localparam int ACC_W = 56;
	localparam int QUO_W = ACC_W - SHIFT;

	localparam logic [ACC_W-1:0] DIV_BIAS = {{(ACC_W - SHIFT){1'b0}}, {SHIFT{1'b1}}};

	localparam int NUM_STAGES = 7;
	localparam int IDX_W      = 3;
	localparam int WDATA_W    = 28;
	localparam int S_TDATA_W  = 104;
	localparam int M_TDATA_W  = 144;

	localparam logic [GAIN_W-1:0] KP_RST   = 24'd52429;
	localparam logic [GAIN_W-1:0] KI_RST   = 24'd7;
	localparam logic [GAIN_W-1:0] KD_RST   = 24'd196608;
	localparam logic [ILIM_W-1:0] ILIM_RST = 28'd12800000;
	localparam logic [OLIM_W-1:0] OLIM_RST = 15'd1000;
	localparam logic [PWM_W-1:0]  BASE_RST = 16'd1000;
	localparam logic [PWM_W-1:0]  PMIN_RST = 16'd0;
	localparam logic [PWM_W-1:0]  PMAX_RST = 16'd2000;

	typedef enum logic [IDX_W-1:0] {
		REG_KP         = 3'd0,
		REG_KI_DT      = 3'd1,
		REG_KD_OVER_DT = 3'd2,
		REG_ILIM       = 3'd3,
		REG_OLIM       = 3'd4,
		REG_BASE       = 3'd5,
		REG_PWM_MIN    = 3'd6,
		REG_PWM_MAX    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki_dt;
		logic [GAIN_W-1:0] kd_over_dt;
		logic [ILIM_W-1:0] integral_limit;
		logic [OLIM_W-1:0] output_limit;
		logic [PWM_W-1:0]  base_throttle;
		logic [PWM_W-1:0]  pwm_min;
		logic [PWM_W-1:0]  pwm_max;
	} cfg_t;

	typedef struct packed {
		logic [NUM_STAGES:1] ld;
		logic                upd;
	} pipe_ctrl_t;

endpackage

>>> src/ahm_lane.sv
module ahm_lane (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ahm_pkg::pipe_ctrl_t                ctrl,
	input  ahm_pkg::cfg_t                      cfg,
	input  logic signed [ahm_pkg::IN_W-1:0]    measured,
	input  logic signed [ahm_pkg::IN_W-1:0]    target,
	output logic signed [ahm_pkg::CORR_W-1:0]  corr
);
	import ahm_pkg::*;

	logic signed [ERR_W-1:0]   err_s1;
	logic signed [ERR_W-1:0]   err_s2;
	logic signed [DIFF_W-1:0]  diff_s2;
	logic signed [SUM_W-1:0]   sum_s2;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [ERR_W-1:0]   prev_q;
	logic signed [SUM_X_W-1:0] sum_raw;
	logic signed [SUM_X_W-1:0] lim_pos;
	logic signed [SUM_X_W-1:0] lim_neg;
	logic signed [SUM_W-1:0]   sum_next;
	logic signed [DIFF_W-1:0]  diff_next;
	logic signed [PKP_W-1:0]   prod_kp;
	logic signed [PKI_W-1:0]   prod_ki;
	logic signed [PKD_W-1:0]   prod_kd;
	logic signed [PKP_W-1:0]   p_kp_s3;
	logic signed [PKI_W-1:0]   p_ki_s3;
	logic signed [PKD_W-1:0]   p_kd_s3;
	logic signed [ACC_W-1:0]   acc_s4;
	logic signed [ACC_W-1:0]   acc_adj;
	logic signed [QUO_W-1:0]   quo;
	logic signed [QUO_W-1:0]   olim_pos;
	logic signed [QUO_W-1:0]   olim_neg;
	logic signed [CORR_W-1:0]  corr_next;
	logic signed [CORR_W-1:0]  corr_s5;

	// The error sum saturates symmetrically before it is stored.
	always_comb begin
		sum_raw = SUM_X_W'(sum_q) + SUM_X_W'(err_s1);
		lim_pos = $signed(SUM_X_W'(cfg.integral_limit));
		lim_neg = -lim_pos;
		if (sum_raw > lim_pos) begin
			sum_next = lim_pos[SUM_W-1:0];
		end else if (sum_raw < lim_neg) begin
			sum_next = lim_neg[SUM_W-1:0];
		end else begin
			sum_next = sum_raw[SUM_W-1:0];
		end
		diff_next = DIFF_W'(err_s1) - DIFF_W'(prev_q);
	end

	assign prod_kp = $signed({1'b0, cfg.kp}) * err_s2;
	assign prod_ki = $signed({1'b0, cfg.ki_dt}) * sum_s2;
	assign prod_kd = $signed({1'b0, cfg.kd_over_dt}) * diff_s2;

	// Division by a power of two rounds toward zero.
	always_comb begin
		acc_adj  = acc_s4 + $signed(acc_s4[ACC_W-1] ? DIV_BIAS : '0);
		quo      = acc_adj[ACC_W-1:SHIFT];
		olim_pos = $signed(QUO_W'(cfg.output_limit));
		olim_neg = -olim_pos;
		if (quo > olim_pos) begin
			corr_next = olim_pos[CORR_W-1:0];
		end else if (quo < olim_neg) begin
			corr_next = olim_neg[CORR_W-1:0];
		end else begin
			corr_next = quo[CORR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
		end else if (ctrl.upd) begin
			sum_q  <= sum_next;
			prev_q <= err_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld[1]) begin
			err_s1 <= ERR_W'(target) - ERR_W'(measured);
		end
		if (ctrl.ld[2]) begin
			err_s2  <= err_s1;
			sum_s2  <= sum_next;
			diff_s2 <= diff_next;
		end
		if (ctrl.ld[3]) begin
			p_kp_s3 <= prod_kp;
			p_ki_s3 <= prod_ki;
			p_kd_s3 <= prod_kd;
		end
		if (ctrl.ld[4]) begin
			acc_s4 <= ACC_W'(p_kp_s3) + ACC_W'(p_ki_s3) + ACC_W'(p_kd_s3);
		end
		if (ctrl.ld[5]) begin
			corr_s5 <= corr_next;
		end
	end

	assign corr = corr_s5;

endmodule

>>> src/ahm_mixer.sv
module ahm_mixer (
	input  logic                               clk,
	input  ahm_pkg::pipe_ctrl_t                ctrl,
	input  ahm_pkg::cfg_t                      cfg,
	input  logic signed [ahm_pkg::CORR_W-1:0]  corr [ahm_pkg::NUM_AXES],
	output logic [ahm_pkg::M_TDATA_W-1:0]      tdata
);
	import ahm_pkg::*;

	logic signed [MIX_W-1:0]  base;
	logic signed [MIX_W-1:0]  r;
	logic signed [MIX_W-1:0]  p;
	logic signed [MIX_W-1:0]  y;
	logic signed [MIX_W-1:0]  lo;
	logic signed [MIX_W-1:0]  hi;
	logic signed [MIX_W-1:0]  mix_next [NUM_MOTORS];
	logic signed [MIX_W-1:0]  mix_s6 [NUM_MOTORS];
	logic signed [MIX_W-1:0]  clip_hi [NUM_MOTORS];
	logic [PWM_W-1:0]         sat_next [NUM_MOTORS];
	logic signed [CORR_W-1:0] corr_s6 [NUM_AXES];
	logic [PWM_W-1:0]         motor_s7 [NUM_MOTORS];
	logic signed [CORR_W-1:0] corr_s7 [NUM_AXES];

	always_comb begin
		base = $signed(MIX_W'(cfg.base_throttle));
		r    = MIX_W'(corr[AX_ROLL]);
		p    = MIX_W'(corr[AX_PITCH]);
		y    = MIX_W'(corr[AX_YAW]);
		mix_next[0] = base - r - y - p;
		mix_next[1] = base - r - y + p;
		mix_next[2] = base + r + y - p;
		mix_next[3] = base + r + y + p;
		mix_next[4] = base - r + y;
		mix_next[5] = base + r - y;
	end

	// The upper bound is applied first, so an inverted window gives pwm_min.
	always_comb begin
		lo = $signed(MIX_W'(cfg.pwm_min));
		hi = $signed(MIX_W'(cfg.pwm_max));
		for (int i = 0; i < NUM_MOTORS; i++) begin
			clip_hi[i]  = (mix_s6[i] > hi) ? hi : mix_s6[i];
			sat_next[i] = (clip_hi[i] < lo) ? cfg.pwm_min : clip_hi[i][PWM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld[6]) begin
			mix_s6  <= mix_next;
			corr_s6 <= corr;
		end
		if (ctrl.ld[7]) begin
			motor_s7 <= sat_next;
			corr_s7  <= corr_s6;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_MOTORS; i++) begin
			tdata[i*PWM_W +: PWM_W] = motor_s7[i];
		end
		for (int a = 0; a < NUM_AXES; a++) begin
			tdata[NUM_MOTORS*PWM_W + a*CORR_W +: CORR_W] = corr_s7[a];
		end
	end

endmodule

>>> src/attitude_pid_hex_mixer_top.sv
// Throughput: one transaction per cycle unless m_tready holds the output; the error sum
// and last error of each axis are updated as a tick loads stage 2, which lets the next
// tick follow directly.
// Each lane has three gain multipliers; a stalled output only holds stages that are full.
// Reset clears the error sums, last errors and pipeline valids and loads the default gains, limits and throttle.
module attitude_pid_hex_mixer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// measured_roll, measured_pitch, measured_yaw, target_roll, target_pitch, target_yaw
	input  logic [ahm_pkg::S_TDATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// motor_one .. motor_six, roll_correction, pitch_correction, yaw_correction
	output logic [ahm_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                              wr_en,
	input  logic [ahm_pkg::IDX_W-1:0]         wr_index,
	input  logic [ahm_pkg::WDATA_W-1:0]       wr_data
);
	import ahm_pkg::*;

	cfg_t                     cfg_q;
	pipe_ctrl_t               ctrl;
	logic [NUM_STAGES:1]      valid_q;
	logic [NUM_STAGES:1]      vin;
	logic [NUM_STAGES+1:1]    rdy;
	logic signed [CORR_W-1:0] corr [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp             <= KP_RST;
			cfg_q.ki_dt          <= KI_RST;
			cfg_q.kd_over_dt     <= KD_RST;
			cfg_q.integral_limit <= ILIM_RST;
			cfg_q.output_limit   <= OLIM_RST;
			cfg_q.base_throttle  <= BASE_RST;
			cfg_q.pwm_min        <= PMIN_RST;
			cfg_q.pwm_max        <= PMAX_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_KP:         cfg_q.kp             <= wr_data[GAIN_W-1:0];
				REG_KI_DT:      cfg_q.ki_dt          <= wr_data[GAIN_W-1:0];
				REG_KD_OVER_DT: cfg_q.kd_over_dt     <= wr_data[GAIN_W-1:0];
				REG_ILIM:       cfg_q.integral_limit <= wr_data[ILIM_W-1:0];
				REG_OLIM:       cfg_q.output_limit   <= wr_data[OLIM_W-1:0];
				REG_BASE:       cfg_q.base_throttle  <= wr_data[PWM_W-1:0];
				REG_PWM_MIN:    cfg_q.pwm_min        <= wr_data[PWM_W-1:0];
				REG_PWM_MAX:    cfg_q.pwm_max        <= wr_data[PWM_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage takes new data when it is empty or its contents move on.
	always_comb begin
		vin = {valid_q[NUM_STAGES-1:1], s_tvalid};
		rdy[NUM_STAGES+1] = m_tready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
		ctrl.ld  = rdy[NUM_STAGES:1] & vin;
		ctrl.upd = ctrl.ld[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 1; k <= NUM_STAGES; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= vin[k];
				end
			end
		end
	end

	assign s_tready = rdy[1];
	assign m_tvalid = valid_q[NUM_STAGES];

	for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
		ahm_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.cfg      (cfg_q),
			.measured ($signed(s_tdata[i*IN_W +: IN_W])),
			.target   ($signed(s_tdata[(NUM_AXES + i)*IN_W +: IN_W])),
			.corr     (corr[i])
		);
	end

	ahm_mixer u_mixer (
		.clk   (clk),
		.ctrl  (ctrl),
		.cfg   (cfg_q),
		.corr  (corr),
		.tdata (m_tdata)
	);

endmodule

>>> src/ahm_checker.sv
`include "assert_macros.svh"

module ahm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ahm_pkg::M_TDATA_W-1:0] m_tdata
);

	`AHM_ASSERT(a_valid_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`AHM_ASSERT(a_data_hold, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")
	`AHM_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input blocked with empty output")
	`AHM_ASSERT(a_corr_range, m_tvalid |-> (m_tdata[111:96] != 16'h8000) && (m_tdata[127:112] != 16'h8000) && (m_tdata[143:128] != 16'h8000), "correction outside its clamp")

endmodule

bind attitude_pid_hex_mixer_top ahm_checker u_checker (.*);

>>> tb/attitude_pid_hex_mixer_top_test.sv
`timescale 1ns / 1ps

module attitude_pid_hex_mixer_top_test;
	import ahm_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int RESET_LEN   = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int FIELD_W     = 16;
	localparam int NUM_FIELDS  = NUM_MOTORS + NUM_AXES;
	localparam int ANGLE_SPAN  = 46080;

	// Field order from the lowest bit up: measured_roll, measured_pitch, measured_yaw,
	// target_roll, target_pitch, target_yaw.
	typedef struct packed {
		logic [IN_W-1:0] target_yaw;
		logic [IN_W-1:0] target_pitch;
		logic [IN_W-1:0] target_roll;
		logic [IN_W-1:0] measured_yaw;
		logic [IN_W-1:0] measured_pitch;
		logic [IN_W-1:0] measured_roll;
	} tick_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 wr_en    = 1'b0;
	logic [IDX_W-1:0]     wr_index = REG_KP;
	logic [WDATA_W-1:0]   wr_data  = '0;

	cfg_t gains = '{
		kp: KP_RST, ki_dt: KI_RST, kd_over_dt: KD_RST, integral_limit: ILIM_RST,
		output_limit: OLIM_RST, base_throttle: BASE_RST, pwm_min: PMIN_RST,
		pwm_max: PMAX_RST
	};
	longint error_sum   [NUM_AXES] = '{0, 0, 0};
	longint prior_error [NUM_AXES] = '{0, 0, 0};

	logic [M_TDATA_W-1:0] motor_words_due [$];

	string field_name [NUM_FIELDS] = '{
		"motor_one", "motor_two", "motor_three", "motor_four", "motor_five",
		"motor_six", "roll_correction", "pitch_correction", "yaw_correction"
	};

	int send_idle_pct   = 20;
	int drain_idle_pct  = 20;
	int hold_off_cycles = 0;
	int ticks_sent      = 0;
	int results_seen    = 0;
	int reg_writes      = 0;
	int mismatches      = 0;
	int cycle_count     = 0;

	attitude_pid_hex_mixer_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [M_TDATA_W-1:0] predict_motor_word(input tick_t t);
		longint measured [NUM_AXES];
		longint target   [NUM_AXES];
		longint err, sum, acc, corr, ilim, olim;
		int     axis_out [NUM_AXES];
		int     mix      [NUM_MOTORS];
		int     base, lo, hi, v, ax, m;
		logic [M_TDATA_W-1:0] word;
		measured[AX_ROLL]  = $signed(t.measured_roll);
		measured[AX_PITCH] = $signed(t.measured_pitch);
		measured[AX_YAW]   = $signed(t.measured_yaw);
		target[AX_ROLL]    = $signed(t.target_roll);
		target[AX_PITCH]   = $signed(t.target_pitch);
		target[AX_YAW]     = $signed(t.target_yaw);
		ilim = longint'(gains.integral_limit);
		olim = longint'(gains.output_limit);
		for (ax = 0; ax < NUM_AXES; ax++) begin
			err = target[ax] - measured[ax];
			sum = error_sum[ax] + err;
			if (sum > ilim)
				sum = ilim;
			if (sum < -ilim)
				sum = -ilim;
			acc = longint'(gains.kp) * err + longint'(gains.ki_dt) * sum
				+ longint'(gains.kd_over_dt) * (err - prior_error[ax]);
			corr = acc / (longint'(1) << SHIFT);
			if (corr > olim)
				corr = olim;
			if (corr < -olim)
				corr = -olim;
			error_sum[ax]   = sum;
			prior_error[ax] = err;
			axis_out[ax]    = int'(corr);
		end
		base = int'(gains.base_throttle);
		mix[0] = base - axis_out[AX_ROLL] - axis_out[AX_YAW] - axis_out[AX_PITCH];
		mix[1] = base - axis_out[AX_ROLL] - axis_out[AX_YAW] + axis_out[AX_PITCH];
		mix[2] = base + axis_out[AX_ROLL] + axis_out[AX_YAW] - axis_out[AX_PITCH];
		mix[3] = base + axis_out[AX_ROLL] + axis_out[AX_YAW] + axis_out[AX_PITCH];
		mix[4] = base - axis_out[AX_ROLL] + axis_out[AX_YAW];
		mix[5] = base + axis_out[AX_ROLL] - axis_out[AX_YAW];
		hi = int'(gains.pwm_max);
		lo = int'(gains.pwm_min);
		for (m = 0; m < NUM_MOTORS; m++) begin
			v = mix[m];
			if (v > hi)
				v = hi;
			if (v < lo)
				v = lo;
			word[m*FIELD_W +: FIELD_W] = v[FIELD_W-1:0];
		end
		for (ax = 0; ax < NUM_AXES; ax++)
			word[(NUM_MOTORS+ax)*FIELD_W +: FIELD_W] = axis_out[ax][FIELD_W-1:0];
		return word;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_motor_word(input logic [M_TDATA_W-1:0] got);
		logic [M_TDATA_W-1:0] want;
		int f;
		results_seen++;
		if (motor_words_due.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with no tick pending", results_seen));
		end else begin
			want = motor_words_due.pop_front();
			for (f = 0; f < NUM_FIELDS; f++) begin
				if (got[f*FIELD_W +: FIELD_W] !== want[f*FIELD_W +: FIELD_W])
					report_mismatch($sformatf("result %0d %s: got 0x%04h, expected 0x%04h",
						results_seen, field_name[f], got[f*FIELD_W +: FIELD_W],
						want[f*FIELD_W +: FIELD_W]));
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				motor_words_due.push_back(
					predict_motor_word(tick_t'(s_tdata[$bits(tick_t)-1:0])));
				ticks_sent++;
			end
			if (m_tvalid && m_tready)
				check_motor_word(m_tdata);
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				m_tready <= 1'b0;
				hold_off_cycles--;
			end else begin
				m_tready <= ($urandom_range(99) >= drain_idle_pct);
			end
		end
	end

	function automatic tick_t make_tick(input int mr, input int mp, input int my,
			input int tr, input int tp, input int ty);
		tick_t t;
		t.measured_roll  = mr[IN_W-1:0];
		t.measured_pitch = mp[IN_W-1:0];
		t.measured_yaw   = my[IN_W-1:0];
		t.target_roll    = tr[IN_W-1:0];
		t.target_pitch   = tp[IN_W-1:0];
		t.target_yaw     = ty[IN_W-1:0];
		return t;
	endfunction

	function automatic tick_t random_tick();
		logic [$bits(tick_t)-1:0] v;
		logic [31:0] a;
		int i;
		for (i = 0; i < 2 * NUM_AXES; i++) begin
			case ($urandom_range(9))
				0:       a = $urandom;
				1, 2:    a = $urandom_range(2 * ANGLE_SPAN) - ANGLE_SPAN;
				default: a = $urandom_range(5120) - 2560;
			endcase
			v[i*IN_W +: IN_W] = a[IN_W-1:0];
		end
		return tick_t'(v);
	endfunction

	// Called on a falling edge; returns on the falling edge after the transaction.
	task automatic send_tick(input tick_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - $bits(tick_t)){1'b0}}, t};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [WDATA_W-1:0] value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		case (idx)
			REG_KP:         gains.kp             = value[GAIN_W-1:0];
			REG_KI_DT:      gains.ki_dt          = value[GAIN_W-1:0];
			REG_KD_OVER_DT: gains.kd_over_dt     = value[GAIN_W-1:0];
			REG_ILIM:       gains.integral_limit = value[ILIM_W-1:0];
			REG_OLIM:       gains.output_limit   = value[OLIM_W-1:0];
			REG_BASE:       gains.base_throttle  = value[PWM_W-1:0];
			REG_PWM_MIN:    gains.pwm_min        = value[PWM_W-1:0];
			REG_PWM_MAX:    gains.pwm_max        = value[PWM_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (motor_words_due.size() != 0)
			@(posedge clk);
		repeat (NUM_STAGES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic reshuffle_gains();
		reg_idx_t idx;
		logic [WDATA_W-1:0] value;
		int i;
		for (i = 0; i < 8; i++) begin
			idx = reg_idx_t'(i);
			case ($urandom_range(7))
				0: value = '0;
				1: value = '1;
				2: value = WDATA_W'($urandom);
				default: begin
					case (idx)
						REG_KP:         value = WDATA_W'($urandom_range(1 << 18));
						REG_KI_DT:      value = WDATA_W'($urandom_range(256));
						REG_KD_OVER_DT: value = WDATA_W'($urandom_range(1 << 19));
						REG_ILIM:       value = WDATA_W'($urandom_range(1 << 24));
						REG_OLIM:       value = WDATA_W'($urandom_range(50, 2000));
						REG_BASE:       value = WDATA_W'($urandom_range(3000));
						REG_PWM_MIN:    value = WDATA_W'($urandom_range(1200));
						REG_PWM_MAX:    value = WDATA_W'($urandom_range(800, 4000));
						default:        value = '0;
					endcase
				end
			endcase
			if ($urandom_range(1))
				write_reg(idx, value);
		end
	endtask

	task automatic test_reset_defaults();
		send_tick(make_tick(0, 0, 0, 0, 0, 0));
		send_tick(make_tick(256, -512, 1024, 0, 0, 0));
		drain();
	endtask

	task automatic test_angle_extremes();
		send_tick(make_tick(ANGLE_SPAN, ANGLE_SPAN, ANGLE_SPAN,
			-ANGLE_SPAN, -ANGLE_SPAN, -ANGLE_SPAN));
		send_tick(make_tick(-ANGLE_SPAN, -ANGLE_SPAN, -ANGLE_SPAN,
			ANGLE_SPAN, ANGLE_SPAN, ANGLE_SPAN));
		send_tick(make_tick(-65536, 65535, -65536, 65535, -65536, 65535));
		send_tick(make_tick(65535, -65536, 65535, -65536, 65535, -65536));
		send_tick(make_tick(0, 0, 0, 5120, 0, 0));
		send_tick(make_tick(0, 0, 0, 0, -5120, 0));
		send_tick(make_tick(0, 0, 0, 0, 0, 5120));
		drain();
	endtask

	task automatic test_integral_clamp();
		write_reg(REG_KP, '0);
		write_reg(REG_KD_OVER_DT, '0);
		write_reg(REG_KI_DT, 28'd65536);
		write_reg(REG_ILIM, 28'd100000);
		write_reg(REG_OLIM, 28'h7FFF);
		repeat (3) send_tick(make_tick(-ANGLE_SPAN, -ANGLE_SPAN, ANGLE_SPAN,
			ANGLE_SPAN, ANGLE_SPAN, -ANGLE_SPAN));
		drain();
		// Lowering the clamp below the sums already held must cut them on the next tick.
		write_reg(REG_ILIM, 28'd1000);
		send_tick(make_tick(0, 0, 0, 0, 0, 0));
		drain();
		write_reg(REG_ILIM, '0);
		send_tick(make_tick(100, 200, 300, 0, 0, 0));
		drain();
		write_reg(REG_ILIM, '1);
		repeat (2) send_tick(make_tick(65535, 65535, -65536, -65536, -65536, 65535));
		drain();
	endtask

	task automatic test_motor_window();
		write_reg(REG_KP, 28'hFFFFFF);
		write_reg(REG_KI_DT, '0);
		write_reg(REG_KD_OVER_DT, 28'hFFFFFF);
		write_reg(REG_OLIM, '0);
		send_tick(make_tick(ANGLE_SPAN, 0, -ANGLE_SPAN, 0, ANGLE_SPAN, 0));
		drain();
		write_reg(REG_OLIM, 28'h7FFF);
		send_tick(make_tick(-ANGLE_SPAN, 0, ANGLE_SPAN, 0, ANGLE_SPAN, 0));
		drain();
		write_reg(REG_BASE, '0);
		write_reg(REG_PWM_MAX, 28'hFFFF);
		send_tick(make_tick(0, 0, 0, 1200, -800, 400));
		drain();
		write_reg(REG_BASE, 28'hFFFF);
		send_tick(make_tick(0, 0, 0, -1200, 800, -400));
		drain();
		// A window with its floor above its ceiling pins every motor to the floor.
		write_reg(REG_BASE, 28'd1000);
		write_reg(REG_PWM_MIN, 28'd1500);
		write_reg(REG_PWM_MAX, 28'd500);
		send_tick(make_tick(300, -300, 600, 0, 0, 0));
		drain();
		write_reg(REG_KP, '0);
		write_reg(REG_KD_OVER_DT, '0);
		write_reg(REG_PWM_MIN, '0);
		write_reg(REG_PWM_MAX, 28'd2000);
		send_tick(make_tick(ANGLE_SPAN, ANGLE_SPAN, ANGLE_SPAN, 0, 0, 0));
		drain();
	endtask

	task automatic test_random_ticks(input int count, input int send_pct, input int drain_pct);
		int sent;
		send_idle_pct  = send_pct;
		drain_idle_pct = drain_pct;
		sent = 0;
		while (sent < count) begin
			drain();
			reshuffle_gains();
			repeat ($urandom_range(20, 80)) begin
				send_tick(random_tick());
				sent++;
			end
		end
		drain();
	endtask

	task automatic test_output_backpressure();
		send_idle_pct   = 0;
		drain_idle_pct  = 0;
		hold_off_cycles = 300;
		repeat (48) send_tick(random_tick());
		drain();
	endtask

	initial begin
		repeat (RESET_LEN) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_angle_extremes();
		test_integral_clamp();
		test_motor_window();
		test_random_ticks(500, 32, 67);
		test_random_ticks(500, 67, 32);
		test_random_ticks(550, 0, 0);
		test_output_backpressure();

		drain();
		if (motor_words_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", motor_words_due.size()));
		$display("Covered %0d control ticks and %0d results across %0d register writes.",
			ticks_sent, results_seen, reg_writes);
		$display("Included angle extremes, integral clamping, PWM limits and a long stall.");
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
